FILE: sv/pfe_pkg.sv
`timescale 1ns / 1ps
// Package for the printf format engine: parser, divider and sequencer types,
// character codes and the digit-to-ASCII helper. No dependencies.
package pfe_pkg;

    localparam int ARG_W = 64;

    // ASCII codes the parser and the printer use
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_XU      = 8'h58;
    localparam logic [7:0] CH_A_LOW   = 8'h61;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_L       = 8'h6c;
    localparam logic [7:0] CH_O       = 8'h6f;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X       = 8'h78;

    // Argument sizes in words
    localparam logic [2:0] WORDS_NONE = 3'd0;
    localparam logic [2:0] WORDS_ONE  = 3'd1;
    localparam logic [2:0] WORDS_TWO  = 3'd2;
    localparam logic [2:0] WORDS_FOUR = 3'd4;

    // Divide by ten: q = (x * RECIP10) >> RECIP_SHIFT, exact for x below 2560
    localparam logic [12:0] RECIP10     = 13'd3277;
    localparam int          RECIP_SHIFT = 15;
    localparam logic [11:0] TEN         = 12'd10;
    localparam logic [2:0]  DEC_LAST_STEP = 3'd7;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_LENGTH = 3'd1,
        PH_SHORT  = 3'd2,
        PH_LONG   = 3'd3,
        PH_SPEC   = 3'd4,
        PH_WAIT   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        LEN_DEFAULT = 3'd0,
        LEN_HH      = 3'd1,
        LEN_H       = 3'd2,
        LEN_L       = 3'd3,
        LEN_LL      = 3'd4
    } len_t;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_CHAR = 3'd1,
        KIND_SDEC = 3'd2,
        KIND_UDEC = 3'd3,
        KIND_HEX  = 3'd4,
        KIND_OCT  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        RESP_STATUS = 2'd0,
        RESP_CHAR   = 2'd1,
        RESP_NUMBER = 2'd2
    } resp_kind_t;

    typedef enum logic [1:0] {
        RADIX_OCT = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        DIV_NONE = 2'd0,
        DIV_LOAD = 2'd1,
        DIV_NEXT = 2'd2
    } div_cmd_t;

    typedef enum logic {
        DS_IDLE = 1'b0,
        DS_RUN  = 1'b1
    } div_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE    = 3'd0,
        SEQ_CONVERT = 3'd1,
        SEQ_SIGN    = 3'd2,
        SEQ_READ    = 3'd3,
        SEQ_DIGIT   = 3'd4
    } seq_state_t;

    // Parser decision for the beat being accepted
    typedef struct packed {
        resp_kind_t        kind;
        logic [7:0]        ch;
        logic              negative;
        radix_t            radix;
        logic [ARG_W-1:0]  magnitude;
        logic              need_arg;
        logic [2:0]        arg_words;
    } pfe_resp_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic       digit_ready;
        logic [3:0] digit;
        logic       quotient_zero;
    } div_status_t;

    function automatic logic [2:0] words_for_len(input len_t len);
        logic [2:0] w;
        case (len)
            LEN_LL:  w = WORDS_FOUR;
            LEN_L:   w = WORDS_TWO;
            default: w = WORDS_ONE;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'b0000, d};
        else
            c = CH_A_LOW + {4'b0000, d} - 8'd10;
        return c;
    endfunction

endpackage

FILE: sv/pfe_in_if.sv
`timescale 1ns / 1ps
// Input channel: format character or argument beat with valid/ready.
// Stand-alone; no package needed.
interface pfe_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  format_char;
    logic [63:0] arg_value;

    modport source (output valid, action, format_char, arg_value, input ready);
    modport sink   (input valid, action, format_char, arg_value, output ready);
endinterface

FILE: sv/pfe_out_if.sv
`timescale 1ns / 1ps
// Output channel: one printed character or status beat with valid/ready.
// Stand-alone; no package needed.
interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;
    logic       need_arg;
    logic [2:0] arg_words;

    modport source (output valid, out_char, char_valid, last, need_arg, arg_words,
                    input ready);
    modport sink   (input valid, out_char, char_valid, last, need_arg, arg_words,
                    output ready);
endinterface

FILE: sv/pfe_parser.sv
`timescale 1ns / 1ps
// Format string parser: phase, length and pending-kind registers, decides what
// each accepted beat prints and prepares the argument magnitude. Uses pfe_pkg.
module pfe_parser
    import pfe_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             action,
    input  logic [7:0]       format_char,
    input  logic [ARG_W-1:0] arg_value,
    output pfe_resp_t        resp
);

    localparam int BITS1 = WORD_BITS;
    localparam int BITS2 = 2 * WORD_BITS;
    localparam int BITS4 = (4 * WORD_BITS > ARG_W) ? ARG_W : 4 * WORD_BITS;
    localparam logic [ARG_W-1:0] MASK1 = (BITS1 >= ARG_W) ? '1 :
                                         ((64'd1 << BITS1) - 64'd1);
    localparam logic [ARG_W-1:0] MASK2 = (BITS2 >= ARG_W) ? '1 :
                                         ((64'd1 << BITS2) - 64'd1);
    localparam logic [ARG_W-1:0] MASK4 = (BITS4 >= ARG_W) ? '1 :
                                         ((64'd1 << BITS4) - 64'd1);

    phase_t phase_reg, phase_next;
    len_t   len_reg,   len_next;
    kind_t  kind_reg,  kind_next;

    kind_t            spec_kind;
    logic             do_spec;
    resp_kind_t       rkind;
    logic [7:0]       rch;
    logic [ARG_W-1:0] mask;
    logic             sign_bit;
    logic [ARG_W-1:0] masked;
    logic             negative;
    logic [ARG_W-1:0] magnitude;

    // Conversion specifier decode
    always_comb
    begin
        case (format_char) inside
            CH_C:             spec_kind = KIND_CHAR;
            CH_D, CH_I:       spec_kind = KIND_SDEC;
            CH_U:             spec_kind = KIND_UDEC;
            CH_X, CH_XU, CH_P: spec_kind = KIND_HEX;
            CH_O:             spec_kind = KIND_OCT;
            default:          spec_kind = KIND_NONE;
        endcase
    end

    // Next parser state and what this beat prints
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        do_spec    = 1'b0;
        rkind      = RESP_STATUS;
        rch        = CH_NUL;
        if (!action) begin
            if (format_char == CH_NUL) begin
                phase_next = PH_NORMAL;
                len_next   = LEN_DEFAULT;
                kind_next  = KIND_NONE;
            end else begin
                unique case (phase_reg)
                    PH_NORMAL:
                    begin
                        if (format_char == CH_PERCENT) begin
                            phase_next = PH_LENGTH;
                        end else begin
                            rkind = RESP_CHAR;
                            rch   = format_char;
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (format_char == CH_H) begin
                            len_next   = LEN_H;
                            phase_next = PH_SHORT;
                        end else if (format_char == CH_L) begin
                            len_next   = LEN_L;
                            phase_next = PH_LONG;
                        end else begin
                            do_spec = 1'b1;
                        end
                    end
                    PH_SHORT:
                    begin
                        if (format_char == CH_H) begin
                            len_next   = LEN_HH;
                            phase_next = PH_SPEC;
                        end else begin
                            do_spec = 1'b1;
                        end
                    end
                    PH_LONG:
                    begin
                        if (format_char == CH_L) begin
                            len_next   = LEN_LL;
                            phase_next = PH_SPEC;
                        end else begin
                            do_spec = 1'b1;
                        end
                    end
                    PH_SPEC:
                    begin
                        do_spec = 1'b1;
                    end
                    PH_WAIT:
                    begin
                        // characters are ignored while an argument is due
                    end
                    default:
                    begin
                        phase_next = PH_NORMAL;
                        len_next   = LEN_DEFAULT;
                        kind_next  = KIND_NONE;
                    end
                endcase
            end
        end else if (phase_reg == PH_WAIT) begin
            if (kind_reg == KIND_CHAR) begin
                rkind = RESP_CHAR;
                rch   = arg_value[7:0];
            end else begin
                rkind = RESP_NUMBER;
            end
            phase_next = PH_NORMAL;
            len_next   = LEN_DEFAULT;
            kind_next  = KIND_NONE;
        end

        // Specifier character: "%%", a known conversion, or dropped
        if (do_spec) begin
            if (format_char == CH_PERCENT) begin
                rkind      = RESP_CHAR;
                rch        = CH_PERCENT;
                phase_next = PH_NORMAL;
                len_next   = LEN_DEFAULT;
                kind_next  = KIND_NONE;
            end else if (spec_kind != KIND_NONE) begin
                kind_next  = spec_kind;
                phase_next = PH_WAIT;
            end else begin
                phase_next = PH_NORMAL;
                len_next   = LEN_DEFAULT;
                kind_next  = KIND_NONE;
            end
        end
    end

    // Argument cut to its length, sign-extended and negated for signed decimal
    always_comb
    begin
        case (len_reg)
            LEN_LL:
            begin
                mask     = MASK4;
                sign_bit = arg_value[BITS4-1];
            end
            LEN_L:
            begin
                mask     = MASK2;
                sign_bit = arg_value[BITS2-1];
            end
            default:
            begin
                mask     = MASK1;
                sign_bit = arg_value[BITS1-1];
            end
        endcase
        masked   = arg_value & mask;
        negative = (kind_reg == KIND_SDEC) && sign_bit;
        if (negative)
            magnitude = ~(masked | ~mask) + 64'd1;
        else
            magnitude = masked;
    end

    // Decision record
    always_comb
    begin
        resp.kind      = rkind;
        resp.ch        = rch;
        resp.negative  = negative;
        resp.magnitude = magnitude;
        case (kind_reg)
            KIND_HEX: resp.radix = RADIX_HEX;
            KIND_OCT: resp.radix = RADIX_OCT;
            default:  resp.radix = RADIX_DEC;
        endcase
        resp.need_arg = (phase_next == PH_WAIT);
        if (phase_next != PH_WAIT)
            resp.arg_words = WORDS_NONE;
        else if (kind_next == KIND_CHAR)
            resp.arg_words = WORDS_ONE;
        else
            resp.arg_words = words_for_len(len_next);
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_NORMAL;
            len_reg   <= LEN_DEFAULT;
            kind_reg  <= KIND_NONE;
        end else if (accept) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

FILE: sv/pfe_divider.sv
`timescale 1ns / 1ps
// Shared divide-by-radix unit: one digit per command. Hex and octal shift one
// digit out directly; decimal runs eight byte steps of a constant-reciprocal divide by ten.
// Uses pfe_pkg.
module pfe_divider
    import pfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_cmd_t         cmd,
    input  logic [ARG_W-1:0] load_value,
    input  radix_t           load_radix,
    output div_status_t      status
);

    div_state_t       state_reg, state_next;
    logic             ready_reg, ready_next;
    logic [2:0]       step_reg,  step_next;
    logic [ARG_W-1:0] value_reg, value_next;
    radix_t           radix_reg, radix_next;
    logic [3:0]       rem_reg,   rem_next;
    logic [3:0]       digit_reg, digit_next;

    logic [11:0] dec_x;
    logic [24:0] dec_prod;
    logic [7:0]  dec_q;
    logic [11:0] dec_r;

    // Remainder and next dividend byte, divided by ten
    always_comb
    begin
        dec_x    = {rem_reg, value_reg[ARG_W-1 -: 8]};
        dec_prod = 25'(dec_x) * 25'(RECIP10);
        dec_q    = dec_prod[RECIP_SHIFT +: 8];
        dec_r    = dec_x - 12'(dec_q) * TEN;
    end

    // Sequencing of one digit
    always_comb
    begin
        state_next = state_reg;
        ready_next = 1'b0;
        step_next  = step_reg;
        value_next = value_reg;
        radix_next = radix_reg;
        rem_next   = rem_reg;
        digit_next = digit_reg;
        unique case (cmd)
            DIV_LOAD:
            begin
                value_next = load_value;
                radix_next = load_radix;
                rem_next   = 4'd0;
                step_next  = 3'd0;
                state_next = DS_RUN;
            end
            DIV_NEXT:
            begin
                rem_next   = 4'd0;
                step_next  = 3'd0;
                state_next = DS_RUN;
            end
            default:
            begin
                if (state_reg == DS_RUN) begin
                    case (radix_reg)
                        RADIX_HEX:
                        begin
                            digit_next = value_reg[3:0];
                            value_next = value_reg >> 4;
                            ready_next = 1'b1;
                            state_next = DS_IDLE;
                        end
                        RADIX_OCT:
                        begin
                            digit_next = {1'b0, value_reg[2:0]};
                            value_next = value_reg >> 3;
                            ready_next = 1'b1;
                            state_next = DS_IDLE;
                        end
                        default:
                        begin
                            // quotient bytes shift in as dividend bytes shift out
                            value_next = {value_reg[ARG_W-9:0], dec_q};
                            rem_next   = dec_r[3:0];
                            step_next  = step_reg + 3'd1;
                            if (step_reg == DEC_LAST_STEP) begin
                                digit_next = dec_r[3:0];
                                ready_next = 1'b1;
                                state_next = DS_IDLE;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= DS_IDLE;
            ready_reg <= 1'b0;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        radix_reg <= radix_next;
        rem_reg   <= rem_next;
        digit_reg <= digit_next;
    end

    assign status.digit_ready   = ready_reg;
    assign status.digit         = digit_reg;
    assign status.quotient_zero = (value_reg == '0);

endmodule

FILE: sv/printf_format_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the printf format engine: parser, shared divider, digit store,
// print sequencer and output register. Uses pfe_pkg, pfe_in_if, pfe_out_if.

// A format character beat or an ignored argument beat yields one result beat
// (the character, or a status beat with char_valid low). A %c argument does
// the same. A numeric argument runs the shared divider once per digit, least
// significant first, into the digit store, with eight byte steps of the divide
// by ten per decimal digit and a single shift per hex or octal digit; up to 20
// decimal, 22 octal or 16 hex digits for 64 bits. The characters ('-' first
// for a negative value) then leave one by one while the sink is ready, each
// digit through a registered read of the digit store. The block accepts no
// beat while a number is being converted or printed; every item ends with a
// beat marked last, and need_arg/arg_words report the parser state after that
// item.
module printf_format_engine_unit
    import pfe_pkg::*;
#(
    parameter int WORD_BITS   = 16,
    parameter int DIGIT_DEPTH = 22
)
(
    input  logic      clk,
    input  logic      rst_n,
    pfe_in_if.sink    item,
    pfe_out_if.source result
);

    localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
    localparam int IDX_W = $clog2(DIGIT_DEPTH);

    pfe_resp_t   resp;
    div_cmd_t    div_cmd;
    div_status_t div_status;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             neg_reg,   neg_next;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       char_valid_reg;
    logic       last_reg;
    logic       need_arg_reg;
    logic [2:0] arg_words_reg;

    logic       out_free;
    logic       accept;
    logic       load_en;
    logic [7:0] load_char;
    logic       load_valid;
    logic       load_last;
    logic       load_need;
    logic [2:0] load_words;

    logic             store_we;
    logic [IDX_W-1:0] rd_addr;
    logic [3:0]       rd_data_reg;
    logic [3:0]       digit_store [DIGIT_DEPTH];

    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == SEQ_IDLE) && out_free;
    assign accept     = item.valid && item.ready;

    pfe_parser #(
        .WORD_BITS (WORD_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (item.action),
        .format_char (item.format_char),
        .arg_value   (item.arg_value),
        .resp        (resp)
    );

    pfe_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (div_cmd),
        .load_value (resp.magnitude),
        .load_radix (resp.radix),
        .status     (div_status)
    );

    // Print sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        div_cmd    = DIV_NONE;
        store_we   = 1'b0;
        load_en    = 1'b0;
        load_char  = CH_NUL;
        load_valid = 1'b0;
        load_last  = 1'b0;
        load_need  = 1'b0;
        load_words = WORDS_NONE;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept) begin
                    if (resp.kind == RESP_NUMBER) begin
                        div_cmd    = DIV_LOAD;
                        count_next = '0;
                        neg_next   = resp.negative;
                        state_next = SEQ_CONVERT;
                    end else begin
                        load_en    = 1'b1;
                        load_char  = resp.ch;
                        load_valid = (resp.kind == RESP_CHAR);
                        load_last  = 1'b1;
                        load_need  = resp.need_arg;
                        load_words = resp.arg_words;
                    end
                end
            end
            SEQ_CONVERT:
            begin
                if (div_status.digit_ready) begin
                    store_we   = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (div_status.quotient_zero ||
                        count_reg == CNT_W'(DIGIT_DEPTH - 1)) begin
                        state_next = neg_reg ? SEQ_SIGN : SEQ_READ;
                    end else begin
                        div_cmd = DIV_NEXT;
                    end
                end
            end
            SEQ_SIGN:
            begin
                if (out_free) begin
                    load_en    = 1'b1;
                    load_char  = CH_MINUS;
                    load_valid = 1'b1;
                    state_next = SEQ_READ;
                end
            end
            SEQ_READ:
            begin
                state_next = SEQ_DIGIT;
            end
            SEQ_DIGIT:
            begin
                if (out_free) begin
                    load_en    = 1'b1;
                    load_char  = digit_char(rd_data_reg);
                    load_valid = 1'b1;
                    load_last  = (count_reg == CNT_W'(1));
                    count_next = count_reg - 1'b1;
                    state_next = (count_reg == CNT_W'(1)) ? SEQ_IDLE : SEQ_READ;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
            neg_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
        end
    end

    // Digit store: written least significant first, read back top down
    assign rd_addr = IDX_W'(count_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (store_we)
            digit_store[count_reg[IDX_W-1:0]] <= div_status.digit;
        rd_data_reg <= digit_store[rd_addr];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (load_en) begin
            out_valid_reg <= 1'b1;
        end else if (result.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en) begin
            out_char_reg   <= load_char;
            char_valid_reg <= load_valid;
            last_reg       <= load_last;
            need_arg_reg   <= load_need;
            arg_words_reg  <= load_words;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_char   = out_char_reg;
    assign result.char_valid = char_valid_reg;
    assign result.last       = last_reg;
    assign result.need_arg   = need_arg_reg;
    assign result.arg_words  = arg_words_reg;

endmodule

FILE: verif/pfe_checker.sv
`timescale 1ns / 1ps
// Checker for the printf format engine: watches both channels, predicts the printed
// characters of every accepted beat and compares them with the result beats.
// Depends on pfe_pkg, pfe_in_if and pfe_out_if.
module pfe_checker
    import pfe_pkg::*;
#(
    parameter int WORD_BITS   = 16,
    parameter int DIGIT_DEPTH = 22,
    parameter int MAX_REPORTS = 100
)
(
    input  logic clk,
    input  logic rst_n,
    pfe_in_if    item,
    pfe_out_if   result,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       char_valid;
        logic       last;
        logic       need_arg;
        logic [2:0] arg_words;
    } out_beat_t;

    // Predicted beats, oldest first, and the beats of the item being predicted
    out_beat_t expected_chars[$];
    out_beat_t item_beats[$];

    // Parser copy
    phase_t     phase;
    len_t       len_sel;
    kind_t      kind;
    logic [3:0] digits [DIGIT_DEPTH];

    function automatic logic [2:0] words_of_length(input len_t len);
        if (len == LEN_LL)
            return WORDS_FOUR;
        if (len == LEN_L)
            return WORDS_TWO;
        return WORDS_ONE;
    endfunction

    task automatic queue_char(input logic [7:0] ch, input logic valid);
        out_beat_t b;
        b = '0;
        b.ch = ch;
        b.char_valid = valid;
        item_beats.push_back(b);
    endtask

    task automatic to_normal();
        phase = PH_NORMAL;
        len_sel = LEN_DEFAULT;
        kind = KIND_NONE;
    endtask

    // Specifier letter: %% prints at once, known letters wait for an argument
    task automatic take_spec(input logic [7:0] ch);
        kind_t k;
        k = KIND_NONE;
        case (ch)
            CH_PERCENT:         queue_char(CH_PERCENT, 1'b1);
            CH_C:               k = KIND_CHAR;
            CH_D, CH_I:         k = KIND_SDEC;
            CH_U:               k = KIND_UDEC;
            CH_X, CH_XU, CH_P:  k = KIND_HEX;
            CH_O:               k = KIND_OCT;
            default:            ;
        endcase
        if (k != KIND_NONE)
        begin
            kind = k;
            phase = PH_WAIT;
        end
        else
            to_normal();
    endtask

    task automatic predict_printout(input logic act, input logic [7:0] ch,
                                    input logic [63:0] arg);
        int         nbits;
        int         n;
        int         j;
        logic [63:0] v;
        logic [63:0] radix;
        logic       neg;
        logic       need;
        logic [2:0] words;
        out_beat_t  b;
        item_beats.delete();
        if (!act)
        begin
            if (ch == CH_NUL)
                to_normal();
            else
            begin
                case (phase)
                    PH_NORMAL:
                        if (ch == CH_PERCENT)
                            phase = PH_LENGTH;
                        else
                            queue_char(ch, 1'b1);
                    PH_LENGTH:
                        if (ch == CH_H)
                        begin
                            len_sel = LEN_H;
                            phase = PH_SHORT;
                        end
                        else if (ch == CH_L)
                        begin
                            len_sel = LEN_L;
                            phase = PH_LONG;
                        end
                        else
                            take_spec(ch);
                    PH_SHORT:
                        if (ch == CH_H)
                        begin
                            len_sel = LEN_HH;
                            phase = PH_SPEC;
                        end
                        else
                            take_spec(ch);
                    PH_LONG:
                        if (ch == CH_L)
                        begin
                            len_sel = LEN_LL;
                            phase = PH_SPEC;
                        end
                        else
                            take_spec(ch);
                    PH_SPEC:
                        take_spec(ch);
                    PH_WAIT:
                        ;
                    default:
                        to_normal();
                endcase
            end
        end
        else if (phase == PH_WAIT)
        begin
            // Cut the argument to its words, capped at 64 bits
            nbits = (kind == KIND_CHAR) ? WORD_BITS : words_of_length(len_sel) * WORD_BITS;
            if (nbits > 64)
                nbits = 64;
            v = arg;
            if (nbits < 64)
                v = v & ((64'd1 << nbits) - 64'd1);
            if (kind == KIND_CHAR)
                queue_char(v[7:0], 1'b1);
            else
            begin
                // Signed: extend and take the magnitude, the most negative one included
                neg = 1'b0;
                if (kind == KIND_SDEC && v[nbits-1])
                begin
                    neg = 1'b1;
                    if (nbits < 64)
                        v = v | ~((64'd1 << nbits) - 64'd1);
                    v = 64'd0 - v;
                end
                radix = (kind == KIND_HEX) ? 64'd16 : (kind == KIND_OCT) ? 64'd8 : 64'd10;
                n = 0;
                do
                begin
                    if (n < DIGIT_DEPTH)
                    begin
                        digits[n] = 4'(v % radix);
                        n++;
                    end
                    v = v / radix;
                end
                while (v != 64'd0 && n < DIGIT_DEPTH);
                if (neg)
                    queue_char(CH_MINUS, 1'b1);
                for (j = n; j > 0; j--)
                begin
                    if (digits[j-1] < 4'd10)
                        queue_char(CH_ZERO + {4'b0000, digits[j-1]}, 1'b1);
                    else
                        queue_char(CH_A_LOW + {4'b0000, digits[j-1]} - 8'd10, 1'b1);
                end
            end
            to_normal();
        end

        // Items that print nothing give one status beat
        if (item_beats.size() == 0)
            queue_char(CH_NUL, 1'b0);
        need = (phase == PH_WAIT);
        words = WORDS_NONE;
        if (need)
            words = (kind == KIND_CHAR) ? WORDS_ONE : words_of_length(len_sel);
        for (j = 0; j < item_beats.size(); j++)
        begin
            b = item_beats[j];
            b.need_arg = need;
            b.arg_words = words;
            b.last = (j == item_beats.size() - 1);
            expected_chars.push_back(b);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ERROR %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Predict on accepted input beats, compare accepted result beats
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            to_normal();
            expected_chars.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (item.valid && item.ready)
                predict_printout(item.action, item.format_char, item.arg_value);
            if (result.valid && result.ready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("beat with nothing expected", 64'(result.out_char),
                                    64'd0);
                else
                begin
                    want = expected_chars.pop_front();
                    if (result.out_char !== want.ch)
                        report_mismatch("out_char", 64'(result.out_char), 64'(want.ch));
                    if (result.char_valid !== want.char_valid)
                        report_mismatch("char_valid", 64'(result.char_valid),
                                        64'(want.char_valid));
                    if (result.last !== want.last)
                        report_mismatch("last", 64'(result.last), 64'(want.last));
                    if (result.need_arg !== want.need_arg)
                        report_mismatch("need_arg", 64'(result.need_arg), 64'(want.need_arg));
                    if (result.arg_words !== want.arg_words)
                        report_mismatch("arg_words", 64'(result.arg_words),
                                        64'(want.arg_words));
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the printf format engine: clock, reset, format and argument
// stimulus, result back-pressure and the verdict. Uses pfe_pkg, both channel
// interfaces, pfe_checker and printf_format_engine_unit.
module tb;
    import pfe_pkg::*;

    localparam int WORD_BITS    = 16;
    localparam int DIGIT_DEPTH  = 22;
    localparam int RANDOM_ITEMS = 220;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 250;
    localparam int CYCLE_LIMIT  = 800000;

    // A letter the engine does not know, and a plain printable one
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_PLAIN_A = 8'h41;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    int   hold_left = 0;

    pfe_in_if  item_ch ();
    pfe_out_if result_ch ();

    printf_format_engine_unit #(
        .WORD_BITS   (WORD_BITS),
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    pfe_checker #(
        .WORD_BITS   (WORD_BITS),
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, and one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 99) < 16)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Argument values biased to the edges of each width
    function automatic logic [63:0] pick_arg();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return '1;
            2:       return {48'(rand_word() >> 16), 16'h8000};
            3:       return {$urandom, 32'h8000_0000};
            4:       return 64'h8000_0000_0000_0000;
            5:       return 64'($urandom_range(0, 20));
            6:       return {$urandom, 16'h7fff, 16'h7fff};
            default: return rand_word();
        endcase
    endfunction

    // One input beat; valid stays up until it is taken
    task automatic send_beat(input logic act, input logic [7:0] ch, input logic [63:0] arg);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 16)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= act;
        item_ch.format_char <= ch;
        item_ch.arg_value <= arg;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(1'b0, s[i], rand_word());
    endtask

    task automatic send_arg(input logic [63:0] arg);
        send_beat(1'b1, 8'($urandom), arg);
    endtask

    // Length letters: 0 none, 1 h, 2 hh, 3 l, 4 ll; returns the beats sent
    task automatic send_length(input int lsel, output int n);
        n = 0;
        if (lsel == 1 || lsel == 2)
        begin
            send_text("h");
            n++;
        end
        if (lsel == 2)
        begin
            send_text("h");
            n++;
        end
        if (lsel == 3 || lsel == 4)
        begin
            send_text("l");
            n++;
        end
        if (lsel == 4)
        begin
            send_text("l");
            n++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // One random stretch of format text; counts the beats that do something
    task automatic send_random_sequence(output int counted);
        logic [7:0] spec_set [8];
        logic [7:0] c;
        int         r;
        int         lsel;
        int         nl;
        r = $urandom_range(0, 99);
        lsel = $urandom_range(0, 4);
        spec_set = '{CH_C, CH_D, CH_I, CH_U, CH_X, CH_XU, CH_P, CH_O};
        counted = 0;
        if (r < 52)
        begin
            // Full conversion, sometimes with stray characters while waiting
            send_text("%");
            send_length(lsel, nl);
            send_beat(1'b0, spec_set[$urandom_range(0, 7)], rand_word());
            if (r >= 45)
                repeat ($urandom_range(1, 3))
                    send_beat(1'b0, 8'($urandom_range(1, 255)), rand_word());
            send_arg(pick_arg());
            counted = nl + 3;
        end
        else if (r < 64)
        begin
            // Plain text
            repeat ($urandom_range(1, 4))
            begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_PERCENT)
                    c = CH_PLAIN_A;
                send_beat(1'b0, c, rand_word());
                counted++;
            end
        end
        else if (r < 69)
        begin
            send_text("%%");
            counted = 2;
        end
        else if (r < 76)
        begin
            // Unknown letter, or a length letter that does not fit
            send_text("%");
            send_length(lsel, nl);
            c = 8'($urandom_range(1, 255));
            case (c)
                CH_NUL, CH_PERCENT, CH_H, CH_L, CH_C, CH_D, CH_I, CH_U,
                CH_X, CH_XU, CH_P, CH_O: c = CH_S;
                default: ;
            endcase
            if (lsel != 0 && $urandom_range(0, 1))
                c = (lsel == 1) ? CH_L : (lsel == 3) ? CH_H : ($urandom_range(0, 1) ? CH_H : CH_L);
            send_beat(1'b0, c, rand_word());
            counted = nl + 2;
        end
        else if (r < 84)
        begin
            // Conversion cut short by the string end
            send_text("%");
            send_length(lsel, nl);
            if ($urandom_range(0, 1))
            begin
                send_beat(1'b0, spec_set[$urandom_range(0, 7)], rand_word());
                nl++;
            end
            send_beat(1'b0, CH_NUL, rand_word());
            counted = nl + 2;
        end
        else if (r < 88)
            send_arg(rand_word());
        else if (r < 94)
            send_beat(1'b0, CH_NUL, rand_word());
        else
        begin
            // Any beat at all, then usually a string end
            send_beat(1'($urandom), 8'($urandom), rand_word());
            if ($urandom_range(0, 1))
                send_beat(1'b0, CH_NUL, rand_word());
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int  count;
        int  n;
        bit  held;
        bit  paused;
        count = 0;
        held = 1'b0;
        paused = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.action = 1'b0;
        item_ch.format_char = 8'h00;
        item_ch.arg_value = 64'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, each conversion family and the corner cases
        send_beat(1'b0, 8'hff, 64'd0);
        send_arg('1);                           // argument nobody asked for
        send_text("%%");
        send_text("%d");
        send_arg(64'hffff_ffff_ffff_8000);      // most negative word
        send_text("%lld");
        send_arg(64'h8000_0000_0000_0000);      // most negative 64-bit value
        send_text("%llo");
        send_text("z");                         // ignored while waiting
        send_arg('1);
        send_text("%hhu");
        send_arg(64'd0);
        send_text("%c");
        send_arg(64'h1234_5641);
        send_text("%hl");                       // mixed length, dropped
        send_text("%s");                        // unknown, dropped
        send_text("%X");
        send_beat(1'b0, CH_NUL, '1);            // string end while waiting
        wait_drained();

        // Random: idling, a long result hold-off, a full pause, a stretch without idling
        while (count < RANDOM_ITEMS)
        begin
            if (!held && count >= 60)
            begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (!paused && count >= 120)
            begin
                wait_drained();
                paused = 1'b1;
            end
            idle_on = !(count >= 150 && count < 200);
            send_random_sequence(n);
            count += n;
        end
        idle_on = 1'b1;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: printf_format_engine_unit.f
sv/pfe_pkg.sv
sv/pfe_in_if.sv
sv/pfe_out_if.sv
sv/pfe_parser.sv
sv/pfe_divider.sv
sv/printf_format_engine_unit.sv
verif/pfe_checker.sv
verif/tb.sv
